// File: rtl/core/hpt2_pkg.sv
package hpt2_pkg;

  // Default number of fraction bits in every coordinate and coefficient
  localparam int FRAC_BITS_DEF = 16;

  // Fixed widths of the coordinate, packed column and register index
  localparam int COORD_W = 32;
  localparam int COL_W   = 64;
  localparam int CFG_IDX_W = 3;

  // Exact dot product width: two 64-bit products plus the shifted offset
  localparam int SUM_W = 66;

  // Quotient bits that the divider resolves, one above the 32-bit range
  localparam int QUOT_W = 33;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_X_COL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_COL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_W_COL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_X_OFS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_W_OFS = 3'd5;

  // Reset matrix: m10 is one raw step, m11 and m22 are 1.0, the rest zero
  localparam logic [COL_W-1:0]   X_COL_RST = 64'h0000_0001_0000_0000;
  localparam logic [COL_W-1:0]   Y_COL_RST = 64'h0001_0000_0000_0000;
  localparam logic [COL_W-1:0]   W_COL_RST = 64'h0;
  localparam logic [COORD_W-1:0] X_OFS_RST = 32'h0;
  localparam logic [COORD_W-1:0] Y_OFS_RST = 32'h0;
  localparam logic [COORD_W-1:0] W_OFS_RST = 32'h0001_0000;

  // Saturation limits
  localparam logic [COORD_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] NEG_MIN = 32'h8000_0000;

endpackage

// File: rtl/core/homogeneous_point_transform_2d_core.sv
// Projective 2D point transform. A point (x, y) is taken as the row vector
// (x, y, 1) and multiplied by the 3x3 matrix held in the configuration
// registers; the results x' and y' are divided by w and given as signed
// fixed point with FRAC_BITS fraction bits, truncated toward zero and
// saturated to 32 bits (saturated_o marks a clip). A w of exactly zero gives
// zero coordinates and raises w_zero_o. A request is taken on every cycle that
// start_i is high: busy_o stays low, the pipeline never stalls. Each result
// appears for one cycle under out_valid_o, in request order; the receiver
// cannot hold results off, so it must take every strobe. The latency is set
// by the restoring divider, which spends one pipeline stage on overflow
// detection and one per quotient bit (34 stages), behind three stages of
// multiply, sum and magnitude, and one output register. Write the matrix
// only while no request is in flight.
module homogeneous_point_transform_2d_core #(
  parameter int FRAC_BITS = hpt2_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Request channel
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [hpt2_pkg::COORD_W-1:0]   point_x_i,
  input  logic [hpt2_pkg::COORD_W-1:0]   point_y_i,
  // Result channel
  output logic                           out_valid_o,
  output logic [hpt2_pkg::COORD_W-1:0]   out_x_o,
  output logic [hpt2_pkg::COORD_W-1:0]   out_y_o,
  output logic                           w_zero_o,
  output logic                           saturated_o,
  // Configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [hpt2_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [hpt2_pkg::COL_W-1:0]     cfg_data_i
);
  import hpt2_pkg::*;

  localparam int NUM_W = SUM_W + FRAC_BITS;
  localparam int PROD_W = 2 * COORD_W;
  localparam int DIV_LAT = QUOT_W + 1;
  localparam int LAT = DIV_LAT + 4;

  // Configuration is always accepted
  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  logic [COL_W-1:0]   x_col_q, y_col_q, w_col_q;
  logic [COORD_W-1:0] x_ofs_q, y_ofs_q, w_ofs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_col_q <= X_COL_RST;
      y_col_q <= Y_COL_RST;
      w_col_q <= W_COL_RST;
      x_ofs_q <= X_OFS_RST;
      y_ofs_q <= Y_OFS_RST;
      w_ofs_q <= W_OFS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_X_COL: x_col_q <= cfg_data_i;
        REG_Y_COL: y_col_q <= cfg_data_i;
        REG_W_COL: w_col_q <= cfg_data_i;
        REG_X_OFS: x_ofs_q <= cfg_data_i[COORD_W-1:0];
        REG_Y_OFS: y_ofs_q <= cfg_data_i[COORD_W-1:0];
        REG_W_OFS: w_ofs_q <= cfg_data_i[COORD_W-1:0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  // Valid bits travel alongside the data
  logic [LAT-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start_i};
    end
  end

  // Stage 1: six signed 32x32 products, offsets captured alongside
  logic signed [PROD_W-1:0]  px0_q, py0_q, px1_q, py1_q, px2_q, py2_q;
  logic signed [COORD_W-1:0] c0_q, c1_q, c2_q;
  logic signed [COORD_W-1:0] px_s, py_s;
  assign px_s = signed'(point_x_i);
  assign py_s = signed'(point_y_i);

  always_ff @(posedge clk_i) begin
    px0_q <= px_s * signed'(x_col_q[COORD_W-1:0]);
    py0_q <= py_s * signed'(x_col_q[COL_W-1:COORD_W]);
    px1_q <= px_s * signed'(y_col_q[COORD_W-1:0]);
    py1_q <= py_s * signed'(y_col_q[COL_W-1:COORD_W]);
    px2_q <= px_s * signed'(w_col_q[COORD_W-1:0]);
    py2_q <= py_s * signed'(w_col_q[COL_W-1:COORD_W]);
    c0_q  <= signed'(x_ofs_q);
    c1_q  <= signed'(y_ofs_q);
    c2_q  <= signed'(w_ofs_q);
  end

  // Stage 2: exact sums with 2*FRAC_BITS fraction bits
  logic signed [SUM_W-1:0] xs_q, ys_q, ws_q;
  always_ff @(posedge clk_i) begin
    xs_q <= SUM_W'(px0_q) + SUM_W'(py0_q) + (SUM_W'(c0_q) <<< FRAC_BITS);
    ys_q <= SUM_W'(px1_q) + SUM_W'(py1_q) + (SUM_W'(c1_q) <<< FRAC_BITS);
    ws_q <= SUM_W'(px2_q) + SUM_W'(py2_q) + (SUM_W'(c2_q) <<< FRAC_BITS);
  end

  // Stage 3: split into sign and magnitude, align the numerators
  logic [NUM_W-1:0] xn_q, yn_q;
  logic [SUM_W-1:0] wd_q;
  logic             xneg_q, yneg_q, wz_q;
  logic [SUM_W-1:0] xm, ym;
  assign xm = xs_q[SUM_W-1] ? SUM_W'(-xs_q) : SUM_W'(xs_q);
  assign ym = ys_q[SUM_W-1] ? SUM_W'(-ys_q) : SUM_W'(ys_q);

  always_ff @(posedge clk_i) begin
    xn_q   <= NUM_W'(xm) << FRAC_BITS;
    yn_q   <= NUM_W'(ym) << FRAC_BITS;
    wd_q   <= ws_q[SUM_W-1] ? SUM_W'(-ws_q) : SUM_W'(ws_q);
    xneg_q <= xs_q[SUM_W-1] ^ ws_q[SUM_W-1];
    yneg_q <= ys_q[SUM_W-1] ^ ws_q[SUM_W-1];
    wz_q   <= (ws_q == '0);
  end

  // Divider pipelines, one per coordinate
  logic [COORD_W-1:0] qx, qy;
  logic               satx, saty;

  hpt2_div #(.NUM_W(NUM_W), .DEN_W(SUM_W)) u_div_x (
    .clk_i (clk_i),
    .num_i (xn_q),
    .den_i (wd_q),
    .neg_i (xneg_q),
    .res_o (qx),
    .sat_o (satx)
  );

  hpt2_div #(.NUM_W(NUM_W), .DEN_W(SUM_W)) u_div_y (
    .clk_i (clk_i),
    .num_i (yn_q),
    .den_i (wd_q),
    .neg_i (yneg_q),
    .res_o (qy),
    .sat_o (saty)
  );

  // Carry the zero-w flag through the divider latency
  logic [DIV_LAT-1:0] wz_pipe_q;
  always_ff @(posedge clk_i) begin
    wz_pipe_q <= {wz_pipe_q[DIV_LAT-2:0], wz_q};
  end

  // Output register: force zeros when w was zero
  logic [COORD_W-1:0] ox_q, oy_q;
  logic               owz_q, osat_q;
  always_ff @(posedge clk_i) begin
    if (wz_pipe_q[DIV_LAT-1]) begin
      ox_q   <= '0;
      oy_q   <= '0;
      owz_q  <= 1'b1;
      osat_q <= 1'b0;
    end else begin
      ox_q   <= qx;
      oy_q   <= qy;
      owz_q  <= 1'b0;
      osat_q <= satx | saty;
    end
  end

  assign out_valid_o = vld_q[LAT-1];
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign w_zero_o    = owz_q;
  assign saturated_o = osat_q;

endmodule

// File: rtl/core/hpt2_div.sv
module hpt2_div #(
  parameter int NUM_W = 82,
  parameter int DEN_W = 66
) (
  input  logic                         clk_i,
  input  logic [NUM_W-1:0]             num_i,
  input  logic [DEN_W-1:0]             den_i,
  input  logic                         neg_i,
  output logic [hpt2_pkg::COORD_W-1:0] res_o,
  output logic                         sat_o
);
  import hpt2_pkg::*;

  // Overflow check stage, then one stage per quotient bit
  localparam int NS = QUOT_W + 1;
  localparam int CW = (NUM_W > DEN_W + QUOT_W + 1) ? NUM_W : DEN_W + QUOT_W + 1;

  logic [NUM_W-1:0]  r_q   [NS];
  logic [QUOT_W-1:0] q_q   [NS];
  logic [DEN_W-1:0]  d_q   [NS];
  logic              neg_q [NS];
  logic              ovf_q [NS];

  // Quotient at or above 2^33 saturates whatever the sign
  always_ff @(posedge clk_i) begin
    r_q[0]   <= num_i;
    q_q[0]   <= '0;
    d_q[0]   <= den_i;
    neg_q[0] <= neg_i;
    ovf_q[0] <= CW'(num_i) >= (CW'(den_i) << QUOT_W);
  end

  for (genvar s = 1; s < NS; s++) begin : g_stage
    localparam int B = QUOT_W - s;
    logic [CW-1:0] dsh;
    logic          ge;
    assign dsh = CW'(d_q[s-1]) << B;
    assign ge  = CW'(r_q[s-1]) >= dsh;
    always_ff @(posedge clk_i) begin
      r_q[s]   <= ge ? NUM_W'(CW'(r_q[s-1]) - dsh) : r_q[s-1];
      q_q[s]   <= q_q[s-1] | (ge ? (QUOT_W'(1) << B) : '0);
      d_q[s]   <= d_q[s-1];
      neg_q[s] <= neg_q[s-1];
      ovf_q[s] <= ovf_q[s-1];
    end
  end

  logic [QUOT_W-1:0] q_fin;
  assign q_fin = q_q[NS-1];

  always_comb begin
    if (neg_q[NS-1]) begin
      sat_o = ovf_q[NS-1] || (q_fin > QUOT_W'(NEG_MIN));
      res_o = sat_o ? NEG_MIN : COORD_W'(~q_fin + QUOT_W'(1));
    end else begin
      sat_o = ovf_q[NS-1] || (q_fin > QUOT_W'(POS_MAX));
      res_o = sat_o ? POS_MAX : q_fin[COORD_W-1:0];
    end
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import hpt2_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int LATENCY = 38;

  // One transformed point as the block returns it
  typedef struct packed {
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic               wz;
    logic               sat;
  } proj_pt_t;

  // One row of the directed table: a point and, where obvious, its answer
  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               known;
    proj_pt_t           ans;
  } point_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [COORD_W-1:0] point_x_i;
  logic [COORD_W-1:0] point_y_i;
  logic               out_valid_o;
  logic [COORD_W-1:0] out_x_o;
  logic [COORD_W-1:0] out_y_o;
  logic               w_zero_o;
  logic               saturated_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [COL_W-1:0]   cfg_data_i;

  // Side band that travels with each request: a typed-in answer, if any
  logic     row_known;
  proj_pt_t row_ans;

  // Matrix copy kept by the testbench
  logic [COL_W-1:0]   mx_col, my_col, mw_col;
  logic [COORD_W-1:0] mx_ofs, my_ofs, mw_ofs;

  proj_pt_t pending_pts[$];
  int       mismatches;
  int       idle_pct;

  homogeneous_point_transform_2d_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .out_valid_o (out_valid_o),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .w_zero_o    (w_zero_o),
    .saturated_o (saturated_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Exact dot product of (px, py, 1) with one matrix column, 2*FRAC fraction bits
  function automatic logic signed [127:0] dot3(logic [31:0] px, logic [31:0] py,
                                               logic [63:0] col, logic [31:0] ofs);
    logic signed [127:0] a, b, ca, cb, c;
    a  = $signed(px);
    b  = $signed(py);
    ca = $signed(col[31:0]);
    cb = $signed(col[63:32]);
    c  = $signed(ofs);
    return a * ca + b * cb + (c <<< FRAC);
  endfunction

  // Truncating division, then clip to the 32-bit signed range
  function automatic logic [31:0] div_clip(logic signed [127:0] num,
                                           logic signed [127:0] den, ref logic sat);
    logic signed [127:0] q;
    q = (num <<< FRAC) / den;
    if (q > 128'sh7FFF_FFFF) begin
      sat = 1'b1;
      return POS_MAX;
    end
    if (q < -128'sh8000_0000) begin
      sat = 1'b1;
      return NEG_MIN;
    end
    return q[31:0];
  endfunction

  function automatic proj_pt_t project(logic [31:0] px, logic [31:0] py);
    logic signed [127:0] xs, ys, ws;
    logic     sat;
    proj_pt_t r;
    xs  = dot3(px, py, mx_col, mx_ofs);
    ys  = dot3(px, py, my_col, my_ofs);
    ws  = dot3(px, py, mw_col, mw_ofs);
    sat = 1'b0;
    r   = '0;
    if (ws == 0) begin
      r.wz = 1'b1;
      return r;
    end
    r.px  = div_clip(xs, ws, sat);
    r.py  = div_clip(ys, ws, sat);
    r.sat = sat;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  // Record each accepted request and check each result strobe
  always @(posedge clk_i) begin
    proj_pt_t want;
    if (start_i && !busy_o)
      pending_pts.push_back(row_known ? row_ans : project(point_x_i, point_y_i));
    if (out_valid_o) begin
      if (pending_pts.size() == 0) begin
        report("unexpected result", out_x_o, 32'h0);
      end else begin
        want = pending_pts.pop_front();
        if (out_x_o !== want.px) report("out_x", out_x_o, want.px);
        if (out_y_o !== want.py) report("out_y", out_y_o, want.py);
        if (w_zero_o !== want.wz) report("w_zero", 32'(w_zero_o), 32'(want.wz));
        if (saturated_o !== want.sat)
          report("saturated", 32'(saturated_o), 32'(want.sat));
      end
    end
  end

  task automatic drain();
    while (pending_pts.size() != 0) @(posedge clk_i);
  endtask

  // Write one register once the pipe is empty; mirror it on acceptance
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_X_COL: mx_col = data;
      REG_Y_COL: my_col = data;
      REG_W_COL: mw_col = data;
      REG_X_OFS: mx_ofs = data[31:0];
      REG_Y_OFS: my_ofs = data[31:0];
      REG_W_OFS: mw_ofs = data[31:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold a request until it is taken; idle first at the current rate
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic known, proj_pt_t ans);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i   <= 1'b1;
    point_x_i <= x;
    point_y_i <= y;
    row_known <= known;
    row_ans   <= ans;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic stop_sending();
    start_i   <= 1'b0;
    row_known <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(262144)) - 131072);
      2: return 32'h0;
      3: return POS_MAX;
      4: return NEG_MIN;
      default: return 32'h0001_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0: return POS_MAX;
      1: return NEG_MIN;
      2, 3, 4: return $urandom();
      default: return 32'($signed($urandom_range(2097152)) - 1048576);
    endcase
  endfunction

  task automatic load_matrix(logic [31:0] c[9]);
    write_reg(REG_X_COL, {c[1], c[0]});
    write_reg(REG_Y_COL, {c[3], c[2]});
    write_reg(REG_W_COL, {c[5], c[4]});
    write_reg(REG_X_OFS, {32'($urandom()), c[6]});
    write_reg(REG_Y_OFS, {32'($urandom()), c[7]});
    write_reg(REG_W_OFS, {32'($urandom()), c[8]});
  endtask

  point_row_t directed[$];

  initial begin
    logic [31:0] c[9];
    proj_pt_t    none;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    point_x_i   = '0;
    point_y_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    row_known   = 1'b0;
    row_ans     = '0;
    mismatches  = 0;
    idle_pct    = 36;
    none        = '0;
    mx_col = X_COL_RST; my_col = Y_COL_RST; mw_col = W_COL_RST;
    mx_ofs = X_OFS_RST; my_ofs = Y_OFS_RST; mw_ofs = W_OFS_RST;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset matrix: out_x is point_y scaled down by 2^FRAC toward zero,
    // out_y is point_y unchanged
    directed = '{
      '{32'h0, 32'h0, 1'b1, '{32'h0, 32'h0, 1'b0, 1'b0}},
      '{POS_MAX, NEG_MIN, 1'b1, '{32'hFFFF_8000, NEG_MIN, 1'b0, 1'b0}},
      '{NEG_MIN, POS_MAX, 1'b1, '{32'h0000_7FFF, POS_MAX, 1'b0, 1'b0}},
      '{32'h0001_0000, 32'hFFFF_0000, 1'b1, '{32'hFFFF_FFFF, 32'hFFFF_0000, 1'b0, 1'b0}},
      '{32'hFFFF_FFFF, 32'h1, 1'b1, '{32'h0, 32'h1, 1'b0, 1'b0}},
      '{32'h5555_5555, 32'hAAAA_AAAA, 1'b1, '{32'hFFFF_AAAB, 32'hAAAA_AAAA, 1'b0, 1'b0}}
    };
    foreach (directed[i]) send_point(directed[i].x, directed[i].y, 1'b1, directed[i].ans);
    stop_sending();

    // Zero w: every point gives zero coordinates and the flag
    write_reg(REG_W_OFS, 64'h0);
    foreach (directed[i])
      send_point(directed[i].x, directed[i].y, 1'b1, '{32'h0, 32'h0, 1'b1, 1'b0});
    stop_sending();

    // Tiny w: large points clip both ways, small ones survive
    write_reg(REG_W_OFS, 64'h1);
    foreach (directed[i]) send_point(directed[i].x, directed[i].y, 1'b0, none);
    stop_sending();
    // Negative w and unknown index, which must be ignored
    write_reg(REG_W_OFS, 64'hFFFF_FFFF_FFFF_0000);
    write_reg(3'd6, '1);
    write_reg(3'd7, '1);
    foreach (directed[i]) send_point(directed[i].x, directed[i].y, 1'b0, none);
    stop_sending();

    // Random part: nine matrix settings over three idling rates
    for (int ph = 0; ph < 9; ph++) begin
      idle_pct = (ph < 3) ? 36 : (ph < 6) ? 76 : 0;
      foreach (c[k]) c[k] = rand_coef();
      if (ph == 8) foreach (c[k]) c[k] = k[0] ? NEG_MIN : POS_MAX;
      if (ph == 7) foreach (c[k]) c[k] = 32'hFFFF_FFFF;
      load_matrix(c);
      for (int n = 0; n < 155; n++) begin
        send_point(rand_coord(), rand_coord(), 1'b0, none);
        // Pause once mid-phase until the pipe runs dry
        if (ph == 1 && n == 70) begin
          stop_sending();
          drain();
        end
      end
      stop_sending();
    end

    drain();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (mismatches == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
